@@ rtl/core/sorted_insert_priority_queue_assert.svh @@
// assertion macros used by the queue top level
`ifndef SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH
`define SORTED_INSERT_PRIORITY_QUEUE_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define SIQ_ASSERT_HOLDS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// same-cycle implication
`define SIQ_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SIQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/siq_pkg.sv @@
`timescale 1ns / 1ps

package siq_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 5;

    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [STATUS_W-1:0]       t_status;
    typedef logic [FILL_W-1:0]         t_fill;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    localparam t_status STATUS_OK    = 2'd0;
    localparam t_status STATUS_EMPTY = 2'd1;
    localparam t_status STATUS_FULL  = 2'd2;

    // broadcast to every cell
    typedef struct packed {
        logic   ins;
        logic   rem;
        t_value key;
    } t_cell_ctl;

    // what a cell shows its neighbors
    typedef struct packed {
        logic   valid;
        logic   lt;
        t_value value;
    } t_cell_link;

endpackage

@@ rtl/core/siq_cell.sv @@
`timescale 1ns / 1ps

module siq_cell (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  siq_pkg::t_cell_ctl   i_ctl,
    input  siq_pkg::t_cell_link  i_left,
    input  siq_pkg::t_cell_link  i_right,
    output siq_pkg::t_cell_link  o_link
);
    import siq_pkg::*;

    logic   r_valid;
    logic   n_valid;
    t_value r_value;
    t_value n_value;
    logic   w_lt;

    // held value sorts strictly ahead of the new key
    assign w_lt = r_valid && (r_value < i_ctl.key);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctl.ins) begin
            n_valid = r_valid | i_left.valid;
            if (w_lt) begin
                n_value = r_value;
            end else if (i_left.lt) begin
                n_value = i_ctl.key;
            end else begin
                n_value = i_left.value;
            end
        end else if (i_ctl.rem) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_link = '{valid: r_valid, lt: w_lt, value: r_value};

endmodule

@@ rtl/core/sorted_insert_priority_queue.sv @@
`timescale 1ns / 1ps

// channel   direction  ports                                   transfer
// command   in         start, busy, i_op, i_value              start && !busy
// result    out        o_valid, o_value_out, o_status,         o_valid, one cycle
//                      o_fill_count
//
// one command per clock: busy never rises, every cell compares with the key at once
// the result appears in the cycle after its command is taken and holds for one cycle
// a command every cycle gives a result every cycle
// synchronous active-low reset empties the chain; cell payloads are not cleared
// the receiver has no back-pressure, results are never held

module sorted_insert_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_op,
    input  siq_pkg::t_value   i_value,
    output logic              o_valid,
    output siq_pkg::t_value   o_value_out,
    output siq_pkg::t_status  o_status,
    output siq_pkg::t_fill    o_fill_count
);
    import siq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    // chain of cells, index 0 holds the smallest value
    t_cell_link w_link [DEPTH];
    t_cell_ctl  w_ctl;
    logic       w_accept;
    logic       w_full;
    logic       w_empty;

    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;

    logic     r_valid;
    t_value   r_value_out;
    t_value   n_value_out;
    t_status  r_status;
    t_status  n_status;

    logic [DEPTH-1:0] w_valid_vec;
    logic [DEPTH-1:0] w_order_ok;

    // assertion helpers
    logic [CW-1:0] w_cells_held;
    logic          w_res_full;
    logic          w_res_empty;
    logic          w_drained;

    // every cell takes its new value at once, so the chain never stalls the sender
    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // the chain is packed from cell 0 upward
    assign w_full  = w_link[DEPTH-1].valid;
    assign w_empty = !w_link[0].valid;

    // full-store insert and empty-store remove leave the chain untouched
    assign w_ctl.ins = w_accept && (i_op == OP_INSERT) && !w_full;
    assign w_ctl.rem = w_accept && (i_op == OP_REMOVE) && !w_empty;
    assign w_ctl.key = i_value;

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            t_cell_link w_left;
            t_cell_link w_right;

            if (g == 0) begin : g_head
                // head takes the key whenever it does not keep its own value
                assign w_left = '{valid: 1'b1, lt: 1'b1, value: '0};
            end else begin : g_mid
                assign w_left = w_link[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                // tail empties on a remove
                assign w_right = '{valid: 1'b0, lt: 1'b0, value: '0};
            end else begin : g_body
                assign w_right = w_link[g+1];
            end

            siq_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_left  (w_left),
                .i_right (w_right),
                .o_link  (w_link[g])
            );

            assign w_valid_vec[g] = w_link[g].valid;

            // a held value never sorts below its left neighbor
            if (g == 0) begin : g_ord_head
                assign w_order_ok[g] = 1'b1;
            end else begin : g_ord_body
                assign w_order_ok[g] = !w_link[g].valid ||
                                       (w_link[g-1].valid &&
                                        (w_link[g-1].value <= w_link[g].value));
            end
        end
    endgenerate

    // fill count and result for the command being taken
    always_comb begin
        n_count     = r_count;
        n_value_out = '0;
        n_status    = STATUS_OK;
        if (w_ctl.ins) begin
            n_count = CW'(r_count + 1'b1);
        end else if (w_ctl.rem) begin
            n_count     = CW'(r_count - 1'b1);
            n_value_out = w_link[0].value;
        end else if (w_accept && (i_op == OP_INSERT)) begin
            n_status = STATUS_FULL;
        end else if (w_accept) begin
            n_status = STATUS_EMPTY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value_out <= n_value_out;
        r_status    <= n_status;
    end

    assign o_valid      = r_valid;
    assign o_value_out  = r_value_out;
    assign o_status     = r_status;
    assign o_fill_count = FILL_W'(r_count);

    assign w_cells_held = CW'($countones(w_valid_vec));
    assign w_res_full   = o_valid && (o_status == STATUS_FULL);
    assign w_res_empty  = o_valid && (o_status == STATUS_EMPTY);
    assign w_drained    = (r_count == '0) && (o_value_out == '0);

`include "sorted_insert_priority_queue_assert.svh"

    // the counter tracks the occupied cells exactly
    `SIQ_ASSERT_HOLDS(a_count_matches_cells, w_cells_held == r_count, "count and cells disagree")
    // the chain stays sorted ascending and packed from the head
    `SIQ_ASSERT_HOLDS(a_chain_sorted, &w_order_ok, "cell chain out of order or not packed")
    // every taken command gives a result in the next cycle
    `SIQ_ASSERT_NEXT(a_result_follows, w_accept, o_valid, "result missing after command")
    // a dropped insert is reported only with the chain full
    `SIQ_ASSERT_IMPL(a_full_status, w_res_full, r_count == CW'(DEPTH), "full status, free cells")
    // an empty remove leaves the chain empty
    `SIQ_ASSERT_IMPL(a_empty_status, w_res_empty, w_drained, "empty status, cells held")

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import siq_pkg::*;

    localparam int QUEUE_DEPTH    = 16;
    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 11;
    localparam int RANDOM_ITEMS   = 900;
    localparam int BLOCK_ITEMS    = 50;
    localparam int MAX_GAP        = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;

    localparam t_value WORD_MAX = 32'sh7fff_ffff;
    localparam t_value WORD_MIN = 32'sh8000_0000;

    // one result as it leaves the queue
    typedef struct {
        t_value  value;
        t_status status;
        t_fill   fill;
    } t_result;

    // one command, optionally with its result written out by hand
    typedef struct {
        logic    op;
        t_value  value;
        bit      fixed;
        t_result result;
    } t_cmd_row;

    logic    i_clk;
    logic    i_rst_n;
    logic    start;
    logic    busy;
    logic    i_op;
    t_value  i_value;
    logic    o_valid;
    t_value  o_value_out;
    t_status o_status;
    t_fill   o_fill_count;

    // sorted contents the queue should hold, ascending from entry 0
    t_value  sorted_cells [QUEUE_DEPTH];
    int      held_values;

    // results still owed by the queue, oldest first
    t_result owed_results [$];

    int      fail_count;
    int      quiet_cycles;

    sorted_insert_priority_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_value_out (o_value_out),
        .o_status    (o_status),
        .o_fill_count(o_fill_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // apply one command to the sorted copy and return what the queue must report
    function automatic t_result apply_to_sorted(input logic op, input t_value val);
        t_result r;
        int      pos;
        int      k;
        r.value  = '0;
        r.status = STATUS_OK;
        if (op == OP_INSERT) begin
            if (held_values >= QUEUE_DEPTH) begin
                // full: value dropped, contents untouched
                r.status = STATUS_FULL;
            end else begin
                // first slot holding a value not below the new one
                pos = 0;
                while (pos < held_values && sorted_cells[pos] < val)
                    pos++;
                for (k = held_values; k > pos; k--)
                    sorted_cells[k] = sorted_cells[k-1];
                sorted_cells[pos] = val;
                held_values++;
            end
        end else begin
            if (held_values == 0) begin
                // empty: nothing to hand out
                r.status = STATUS_EMPTY;
            end else begin
                r.value = sorted_cells[0];
                for (k = 1; k < held_values; k++)
                    sorted_cells[k-1] = sorted_cells[k];
                held_values--;
            end
        end
        r.fill = t_fill'(held_values);
        return r;
    endfunction

    function automatic t_cmd_row cmd_row(input logic op, input t_value val, input bit fixed,
                                         input t_value ev, input t_status es, input t_fill ef);
        t_cmd_row row;
        row.op            = op;
        row.value         = val;
        row.fixed         = fixed;
        row.result.value  = ev;
        row.result.status = es;
        row.result.fill   = ef;
        return row;
    endfunction

    // idle for gap cycles, then hold the command until it transfers
    task automatic send_command(input t_cmd_row row, input int gap);
        t_result predicted;
        repeat (gap) begin
            @(negedge i_clk);
            start   <= 1'b0;
            // junk on the payload while start is low must not matter
            i_op    <= 1'($urandom_range(0, 1));
            i_value <= $urandom;
        end
        @(negedge i_clk);
        start   <= 1'b1;
        i_op    <= row.op;
        i_value <= row.value;
        do @(posedge i_clk); while (busy !== 1'b0);
        // transfer taken at this edge: keep the sorted copy in step either way
        predicted = apply_to_sorted(row.op, row.value);
        if (row.fixed)
            owed_results.push_back(row.result);
        else
            owed_results.push_back(predicted);
    endtask

    // result checker: every strobe must match the oldest owed result
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1) begin
            if (owed_results.size() == 0) begin
                $display("%0t unexpected result: value_out %0d status %0d fill %0d",
                         $time, o_value_out, o_status, o_fill_count);
                fail_count++;
            end else begin
                want = owed_results.pop_front();
                if (o_value_out !== want.value) begin
                    $display("%0t value_out mismatch: expected %0d, actual %0d",
                             $time, want.value, o_value_out);
                    fail_count++;
                end
                if (o_status !== want.status) begin
                    $display("%0t status mismatch: expected %0d, actual %0d",
                             $time, want.status, o_status);
                    fail_count++;
                end
                if (o_fill_count !== want.fill) begin
                    $display("%0t fill_count mismatch: expected %0d, actual %0d",
                             $time, want.fill, o_fill_count);
                    fail_count++;
                end
            end
        end
    end

    // watchdog: cycles in which neither a command nor a result transfers
    always @(posedge i_clk) begin
        if (i_rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog expired with %0d results owed",
                         $time, owed_results.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        t_cmd_row directed [$];
        t_cmd_row row;
        int       insert_pct;
        bit       burst;
        int       n;

        fail_count   = 0;
        quiet_cycles = 0;
        held_values  = 0;
        start        = 1'b0;
        i_op         = OP_INSERT;
        i_value      = '0;
        i_rst_n      = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // remove from an empty queue right out of reset
        directed.push_back(cmd_row(OP_REMOVE, 0, 1, 0, STATUS_EMPTY, 0));
        // extremes go in and come out smallest first
        directed.push_back(cmd_row(OP_INSERT, WORD_MAX, 1, 0, STATUS_OK, 1));
        directed.push_back(cmd_row(OP_INSERT, WORD_MIN, 0, 0, STATUS_OK, 0));
        directed.push_back(cmd_row(OP_REMOVE, 0, 1, WORD_MIN, STATUS_OK, 1));
        directed.push_back(cmd_row(OP_REMOVE, 0, 1, WORD_MAX, STATUS_OK, 0));
        // empty again, payload on a remove must be ignored
        directed.push_back(cmd_row(OP_REMOVE, -1, 1, 0, STATUS_EMPTY, 0));
        // fill to the brim: extremes, duplicates, bit patterns, both signs
        directed.push_back(cmd_row(OP_INSERT, WORD_MAX, 0, 0, STATUS_OK, 0));
        directed.push_back(cmd_row(OP_INSERT, WORD_MIN, 0, 0, STATUS_OK, 0));
        directed.push_back(cmd_row(OP_INSERT, -1, 0, 0, STATUS_OK, 0));
        directed.push_back(cmd_row(OP_INSERT, 0, 0, 0, STATUS_OK, 0));
        directed.push_back(cmd_row(OP_INSERT, 1, 0, 0, STATUS_OK, 0));
        directed.push_back(cmd_row(OP_INSERT, 5, 0, 0, STATUS_OK, 0));
        directed.push_back(cmd_row(OP_INSERT, 5, 0, 0, STATUS_OK, 0));
        directed.push_back(cmd_row(OP_INSERT, -5, 0, 0, STATUS_OK, 0));
        directed.push_back(cmd_row(OP_INSERT, 32'sh4000_0000, 0, 0, STATUS_OK, 0));
        directed.push_back(cmd_row(OP_INSERT, 32'shc000_0000, 0, 0, STATUS_OK, 0));
        directed.push_back(cmd_row(OP_INSERT, 32'sh5555_5555, 0, 0, STATUS_OK, 0));
        directed.push_back(cmd_row(OP_INSERT, 32'shaaaa_aaaa, 0, 0, STATUS_OK, 0));
        directed.push_back(cmd_row(OP_INSERT, 100, 0, 0, STATUS_OK, 0));
        directed.push_back(cmd_row(OP_INSERT, -100, 0, 0, STATUS_OK, 0));
        directed.push_back(cmd_row(OP_INSERT, WORD_MAX - 1, 0, 0, STATUS_OK, 0));
        directed.push_back(cmd_row(OP_INSERT, WORD_MIN + 1, 0, 0, STATUS_OK, 0));
        // insert into a full queue is dropped
        directed.push_back(cmd_row(OP_INSERT, 42, 1, 0, STATUS_FULL, t_fill'(QUEUE_DEPTH)));
        directed.push_back(cmd_row(OP_REMOVE, 0, 1, WORD_MIN, STATUS_OK, t_fill'(QUEUE_DEPTH - 1)));
        // refill the freed slot
        directed.push_back(cmd_row(OP_INSERT, 0, 0, 0, STATUS_OK, 0));

        foreach (directed[i])
            send_command(directed[i], $urandom_range(0, MAX_GAP));

        // random part in blocks, each with its own insert bias and pacing
        insert_pct = 50;
        burst      = 1'b0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % BLOCK_ITEMS == 0) begin
                // low bias drains to empty, high bias pushes into full
                case ($urandom_range(0, 3))
                    0:       insert_pct = 15;
                    1:       insert_pct = 50;
                    2:       insert_pct = 70;
                    default: insert_pct = 92;
                endcase
                // some blocks run back to back with no idle cycles
                burst = ($urandom_range(0, 3) == 0);
            end
            row.fixed = 1'b0;
            row.result = '{value: '0, status: STATUS_OK, fill: '0};
            if ($urandom_range(1, 100) <= insert_pct)
                row.op = OP_INSERT;
            else
                row.op = OP_REMOVE;
            case ($urandom_range(0, 9))
                // narrow range: plenty of duplicates and values near zero
                6, 7:    row.value = t_value'(int'($urandom_range(0, 8)) - 4);
                8:       row.value = $urandom_range(0, 1) ? WORD_MAX : WORD_MIN;
                9:       row.value = t_value'($urandom_range(0, 255));
                default: row.value = $urandom;
            endcase
            send_command(row, burst ? 0 : $urandom_range(0, MAX_GAP));
        end

        @(negedge i_clk);
        start <= 1'b0;

        // the watchdog covers a queue that stops answering
        while (owed_results.size() != 0)
            @(posedge i_clk);
        // catch any stray strobes after the last owed result
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl/core
rtl/core/siq_pkg.sv
rtl/core/siq_cell.sv
rtl/core/sorted_insert_priority_queue.sv
tb/testbench.sv
